[hdl/binary_rank_reduce_2x_defines.svh]
// Assertion macros shared by the binary_rank_reduce_2x checker.
// No dependencies; pulled in with `include by the files that assert.
`ifndef BINARY_RANK_REDUCE_2X_DEFINES_SVH
`define BINARY_RANK_REDUCE_2X_DEFINES_SVH

// Same-cycle implication, clocked on clock, disabled during reset.
`define BRR_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, clocked on clock, disabled during reset.
`define BRR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

[hdl/brr_pkg.sv]
// Shared constants, register codes and stage types for binary_rank_reduce_2x.
// No dependencies.
package brr_pkg;

   localparam int WORD_BITS      = 32;
   localparam int HALF_BITS      = WORD_BITS / 2;
   localparam int RANK_BITS      = 3;
   localparam int MODE_BITS      = 2;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANK   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LAYOUT = 1'd1;

   // layout modes (code 3 behaves as row pairs)
   localparam logic [MODE_BITS-1:0] MODE_PAIRS  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_ROW    = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_COLUMN = 2'd2;

   localparam logic [RANK_BITS-1:0] RANK_MIN    = 3'd1;
   localparam logic [RANK_BITS-1:0] RANK_MAX    = 3'd4;
   localparam logic [RANK_BITS-1:0] RANK_OR_TOP = 3'd2;  // ranks up to here act as OR

   localparam logic [WORD_BITS-1:0] RESET_RANK   = {{(WORD_BITS-1){1'b0}}, 1'b1};

   // registered input transaction plus the settings it was taken under
   typedef struct packed {
      logic [WORD_BITS-1:0] top;
      logic [WORD_BITS-1:0] bottom;
      logic                 last;
      logic [RANK_BITS-1:0] rank;
      logic [MODE_BITS-1:0] mode;
   } item_type;

   // reduction results handed to the pairing / output stage
   typedef struct packed {
      logic [HALF_BITS-1:0] half;
      logic [WORD_BITS-1:0] column_word;
      logic                 last;
      logic                 column;
   } reduced_type;

endpackage

[hdl/brr_reduce.sv]
// Combinational 2x2 rank decision for one registered input transaction.
// Depends on brr_pkg.
module brr_reduce (
   input  brr_pkg::item_type    item,
   output brr_pkg::reduced_type red
);
   import brr_pkg::*;

   logic [RANK_BITS-1:0] eff_rank;
   logic [WORD_BITS-1:0] bot_src;
   logic [2:0]           cnt [HALF_BITS];
   logic [HALF_BITS-1:0] half_bits;

   always_comb begin
      case (item.rank)
         3'd0:                   eff_rank = RANK_MIN;
         3'd1, 3'd2, 3'd3, 3'd4: eff_rank = item.rank;
         default:                eff_rank = RANK_MAX;
      endcase
   end

   // single row: the top word stands in for both rows
   assign bot_src = (item.mode == MODE_ROW) ? item.top : item.bottom;

   always_comb begin
      for (int k = 0; k < HALF_BITS; k++) begin
         cnt[k] = {2'b00, item.top[2*k+1]} + {2'b00, item.top[2*k]}
                + {2'b00, bot_src[2*k+1]}  + {2'b00, bot_src[2*k]};
         half_bits[k] = (cnt[k] >= eff_rank);
      end
   end

   assign red.half        = half_bits;
   assign red.column_word = (eff_rank <= RANK_OR_TOP) ? (item.top | item.bottom)
                                                      : (item.top & item.bottom);
   assign red.last   = item.last;
   assign red.column = (item.mode == MODE_COLUMN);

endmodule

[hdl/brr_pack.sv]
// Half-word pairing state and the output register of binary_rank_reduce_2x.
// Depends on brr_pkg.
module brr_pack (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          stage_valid,
   input  brr_pkg::reduced_type          red,
   output logic                          advance,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [brr_pkg::WORD_BITS-1:0] rsp_tdata,
   output logic                          rsp_tlast
);
   import brr_pkg::*;

   logic                 valid_ff, valid_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic                 last_ff, last_in;
   logic [HALF_BITS-1:0] held_ff, held_in;
   logic                 phase_ff, phase_in;

   // output slot is free or being emptied this cycle
   assign advance = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      last_in  = last_ff;
      held_in  = held_ff;
      phase_in = phase_ff;
      if (advance) begin
         valid_in = 1'b0;
         if (stage_valid) begin
            if (red.column) begin
               valid_in = 1'b1;
               word_in  = red.column_word;
               last_in  = 1'b1;
            end else if (!phase_ff) begin
               if (red.last) begin
                  // unpaired upper half closes the line
                  valid_in = 1'b1;
                  word_in  = {red.half, {HALF_BITS{1'b0}}};
                  last_in  = 1'b1;
               end else begin
                  held_in  = red.half;
                  phase_in = 1'b1;
               end
            end else begin
               valid_in = 1'b1;
               word_in  = {held_ff, red.half};
               last_in  = red.last;
               phase_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         held_ff  <= '0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         held_ff  <= held_in;
         phase_ff <= phase_in;
      end
      word_ff <= word_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = word_ff;
   assign rsp_tlast  = last_ff;

endmodule

[hdl/binary_rank_reduce_2x.sv]
// Top level of the 2x2 binary rank reduction block.
// Depends on brr_pkg, brr_reduce and brr_pack.
//
// Usage:
//  - req_* carries one transaction per source word pair: tdata[31:0] is the
//    top-row word, tdata[63:32] the bottom-row word (bit 31 leftmost), and
//    tlast marks the last word pair of a row pair.
//  - rsp_* carries reduced words: tdata[31:0] is the output word, tlast marks
//    the last word of a destination line.
//  - csr_* writes rank (index 0) and layout mode (index 1); csr_ready is
//    always high. Write only while the block is idle.
// An accepted item is loaded into the input register, and its result then
// into the output register once that slot is free or being emptied. Upper halves
// without tlast produce no result; they are held until the lower half arrives.
// Throughput: one transaction per cycle while rsp_tready keeps the output moving, set by the single reduction pass
// between the input register and the output register.
// Stall: when rsp_tready is low with a result waiting, the input register
// still fills once; req_tready drops only when both stages are occupied.
// Reset (synchronous, active high) empties both stages, clears the pairing
// state and loads rank 1, row-pair layout.
module binary_rank_reduce_2x (
   input  logic                               clock,
   input  logic                               reset,
   // tdata: top_word [31:0], bottom_word [63:32]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [2*brr_pkg::WORD_BITS-1:0]    req_tdata,
   input  logic                               req_tlast,
   // tdata: out_word [31:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [brr_pkg::WORD_BITS-1:0]      rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [brr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [brr_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import brr_pkg::*;

   logic [RANK_BITS-1:0] rank_ff, rank_in;
   logic [MODE_BITS-1:0] mode_ff, mode_in;
   logic                 stage_valid_ff, stage_valid_in;
   item_type             item_ff, item_in;
   reduced_type          red;
   logic                 advance;
   logic                 req_take;

   // configuration: always ready, one register per write transaction
   assign csr_ready = 1'b1;

   always_comb begin
      rank_in = rank_ff;
      mode_in = mode_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RANK:   rank_in = csr_wdata;
            CSR_LAYOUT: mode_in = csr_wdata[MODE_BITS-1:0];
            default:    ;
         endcase
      end
   end

   // input register: refills whenever its content moves on this cycle
   assign req_tready = !stage_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      item_in        = item_ff;
      if (req_take) begin
         stage_valid_in = 1'b1;
         item_in.top    = req_tdata[WORD_BITS-1:0];
         item_in.bottom = req_tdata[2*WORD_BITS-1:WORD_BITS];
         item_in.last   = req_tlast;
         item_in.rank   = rank_ff;
         item_in.mode   = mode_ff;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff        <= RESET_RANK[RANK_BITS-1:0];
         mode_ff        <= MODE_PAIRS;
         stage_valid_ff <= 1'b0;
      end else begin
         rank_ff        <= rank_in;
         mode_ff        <= mode_in;
         stage_valid_ff <= stage_valid_in;
      end
      item_ff <= item_in;
   end

   brr_reduce u_reduce (
      .item (item_ff),
      .red  (red)
   );

   brr_pack u_pack (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid_ff),
      .red         (red),
      .advance     (advance),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

[hdl/brr_checker.sv]
// Port-level checks for binary_rank_reduce_2x, bound to the top level.
// Depends on brr_pkg and binary_rank_reduce_2x_defines.svh.
`include "binary_rank_reduce_2x_defines.svh"

module brr_port_checks (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          req_tlast,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [brr_pkg::WORD_BITS-1:0] rsp_tdata,
   input logic                          rsp_tlast
);
   import brr_pkg::*;

   // a stalled result holds its value
   `BRR_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // input side never stalls while the output slot can drain
   `BRR_ASSERT_SAME(a_req_ready, !rsp_tvalid || rsp_tready, req_tready)

   // a line-ending transaction yields a result when the output slot can drain while it sits in the input register
   `BRR_ASSERT_NEXT(a_last_result,
      (req_tvalid && req_tready && req_tlast) ##1 (!rsp_tvalid || rsp_tready),
      rsp_tvalid)

   // a new result traces back to a transaction taken through the input and output registers
   `BRR_ASSERT_SAME(a_rsp_origin, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2))

endmodule

bind binary_rank_reduce_2x brr_port_checks u_port_checks (.*);
